FILE: rtl/shxfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shxfp_pkg
// Types and constants of the sync header xor frame parser.
// ----------------------------------------------------------------------------
package shxfp_pkg;

  localparam logic [7:0] SYNC_FIRST     = 8'h55;
  localparam logic [7:0] SYNC_SECOND    = 8'hAA;
  localparam logic [7:0] CMD_CONFIG     = 8'hFF;
  localparam logic [7:0] CONFIG_MIN_LEN = 8'd3;
  localparam int unsigned NUM_REPORTS   = 4;

  localparam logic [5:0] GAMEPAD_SIZE_RST  = 6'd63;
  localparam logic [5:0] KEYBOARD_SIZE_RST = 6'd8;
  localparam logic [5:0] MOUSE_SIZE_RST    = 6'd5;
  localparam logic [5:0] TOUCH_SIZE_RST    = 6'd6;

  typedef enum logic [1:0] {
    REG_GAMEPAD_SIZE  = 2'd0,
    REG_KEYBOARD_SIZE = 2'd1,
    REG_MOUSE_SIZE    = 2'd2,
    REG_TOUCH_SIZE    = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    PH_SYNC1   = 5'b00001,
    PH_SYNC2   = 5'b00010,
    PH_LEN     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    VERD_REPORT_OK    = 3'd0,
    VERD_CONFIG_OK    = 3'd1,
    VERD_CONFIG_SHORT = 3'd2,
    VERD_LENGTH_WRONG = 3'd3,
    VERD_UNKNOWN_CMD  = 3'd4,
    VERD_CHECKSUM_ERR = 3'd5
  } verdict_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } out_kind_t;

endpackage

FILE: rtl/shxfp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shxfp_in_if
// Received byte channel: valid, ready and one byte per item.
// ----------------------------------------------------------------------------
interface shxfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/shxfp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shxfp_out_if
// Result channel: payload bytes passed on and end-of-frame verdicts.
// ----------------------------------------------------------------------------
interface shxfp_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [2:0] verdict;
  logic [7:0] command;
  logic [7:0] frame_length;

  modport source (
    output valid, output out_kind, output data_byte, output byte_index,
    output verdict, output command, output frame_length, input ready
  );
  modport sink (
    input valid, input out_kind, input data_byte, input byte_index,
    input verdict, input command, input frame_length, output ready
  );
endinterface

FILE: rtl/sync_header_xor_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_header_xor_frame_parser
// Hunts for the 0x55 0xAA sync pair, reads a length byte, passes payload
// bytes on with their index and gives one verdict at the checksum byte.
// A result is registered and is on the output in the cycle after its item is accepted.
// Throughput: one item per cycle; the output register holds a result while
// the next item is taken whenever the sink takes the current one.
// Reset: synchronous, active low; phase returns to sync hunt, frame state
// clears and the report size registers take their defaults.
// ----------------------------------------------------------------------------
module sync_header_xor_frame_parser
  import shxfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  shxfp_in_if.sink    in_ch,
  shxfp_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  logic [5:0] report_size_r [NUM_REPORTS];

  phase_t     phase_r, phase_nxt;
  logic [7:0] expected_length_r, expected_length_nxt;
  logic [7:0] payload_index_r, payload_index_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [7:0] frame_command_r, frame_command_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [7:0] data_byte_r, data_byte_nxt;
  logic [7:0] byte_index_r, byte_index_nxt;
  verdict_t   verdict_r, verdict_nxt;
  logic [7:0] command_r, command_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;

  logic       accept;
  logic       has_result;
  logic [7:0] rx;
  logic [7:0] idx_inc;
  logic [7:0] cmd_cur;
  logic [7:0] want_len;
  verdict_t   judged;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rx          = in_ch.rx_byte;
  assign idx_inc     = payload_index_r + 8'd1;
  assign cmd_cur     = (payload_index_r == 8'd0) ? rx : frame_command_r;
  assign want_len    = {2'b00, report_size_r[frame_command_r[1:0]]} + 8'd1;

  always_comb begin
    if (rx != running_xor_r) begin
      judged = VERD_CHECKSUM_ERR;
    end else if (frame_command_r == CMD_CONFIG) begin
      judged = (expected_length_r < CONFIG_MIN_LEN) ? VERD_CONFIG_SHORT : VERD_CONFIG_OK;
    end else if (frame_command_r[7:2] == 6'd0) begin
      judged = (expected_length_r == want_len) ? VERD_REPORT_OK : VERD_LENGTH_WRONG;
    end else begin
      judged = VERD_UNKNOWN_CMD;
    end
  end

  always_comb begin
    phase_nxt           = phase_r;
    expected_length_nxt = expected_length_r;
    payload_index_nxt   = payload_index_r;
    running_xor_nxt     = running_xor_r;
    frame_command_nxt   = frame_command_r;
    has_result          = 1'b0;
    out_kind_nxt        = KIND_PAYLOAD;
    data_byte_nxt       = 8'd0;
    byte_index_nxt      = 8'd0;
    verdict_nxt         = VERD_REPORT_OK;
    command_nxt         = frame_command_r;
    frame_length_nxt    = expected_length_r;
    case (phase_r)
      PH_SYNC2: begin
        phase_nxt = (rx == SYNC_SECOND) ? PH_LEN : PH_SYNC1;
      end
      PH_LEN: begin
        expected_length_nxt = rx;
        if (rx != 8'd0) begin
          running_xor_nxt   = rx;
          payload_index_nxt = 8'd0;
          phase_nxt         = PH_PAYLOAD;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_PAYLOAD: begin
        frame_command_nxt = cmd_cur;
        has_result        = 1'b1;
        data_byte_nxt     = rx;
        byte_index_nxt    = payload_index_r;
        command_nxt       = cmd_cur;
        running_xor_nxt   = running_xor_r ^ rx;
        payload_index_nxt = idx_inc;
        if (idx_inc >= expected_length_r) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        has_result   = 1'b1;
        out_kind_nxt = KIND_VERDICT;
        verdict_nxt  = judged;
        phase_nxt    = PH_SYNC1;
      end
      default: begin
        phase_nxt = (rx == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = has_result;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_SYNC1;
      expected_length_r <= 8'd0;
      payload_index_r   <= 8'd0;
      running_xor_r     <= 8'd0;
      frame_command_r   <= 8'd0;
      out_valid_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r           <= phase_nxt;
        expected_length_r <= expected_length_nxt;
        payload_index_r   <= payload_index_nxt;
        running_xor_r     <= running_xor_nxt;
        frame_command_r   <= frame_command_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_size_r[REG_GAMEPAD_SIZE]  <= GAMEPAD_SIZE_RST;
      report_size_r[REG_KEYBOARD_SIZE] <= KEYBOARD_SIZE_RST;
      report_size_r[REG_MOUSE_SIZE]    <= MOUSE_SIZE_RST;
      report_size_r[REG_TOUCH_SIZE]    <= TOUCH_SIZE_RST;
    end else if (cfg_we) begin
      report_size_r[cfg_index] <= cfg_data;
    end
  end

  // result payload, loaded with each item that produces one
  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_kind_r     <= out_kind_nxt;
      data_byte_r    <= data_byte_nxt;
      byte_index_r   <= byte_index_nxt;
      verdict_r      <= verdict_nxt;
      command_r      <= command_nxt;
      frame_length_r <= frame_length_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_kind     = out_kind_r;
  assign out_ch.data_byte    = data_byte_r;
  assign out_ch.byte_index   = byte_index_r;
  assign out_ch.verdict      = verdict_r;
  assign out_ch.command      = command_r;
  assign out_ch.frame_length = frame_length_r;

endmodule
